/* hdl/mab_pkg.sv */
package mab_pkg;

	localparam int MAX_DIM = 1024;

	// isqrt of a 16-bit product: eight digit steps, two per stage
	localparam int SQ_STAGES = 4;
	localparam int SQ_STEPS_PER_STAGE = 2;

	// floor(s/3) = (s*683) >> 11 holds exactly for s <= 765
	localparam int DIV3_MUL = 683;
	localparam int DIV3_SHIFT = 11;

	localparam logic [2:0] REG_X_OFFSET = 3'd0;
	localparam logic [2:0] REG_Y_OFFSET = 3'd1;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd2;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_FB_WIDTH = 3'd4;
	localparam logic [2:0] REG_FB_HEIGHT = 3'd5;
	localparam logic [2:0] REG_GLOBAL_ALPHA = 3'd6;

	typedef struct packed {
		logic signed [10:0] x_offset;
		logic signed [10:0] y_offset;
		logic [10:0] image_width;
		logic [10:0] image_height;
		logic [10:0] fb_width;
		logic [10:0] fb_height;
		logic [7:0] global_alpha;
	} cfg_t;

	// per-pixel data that rides alongside the square root
	typedef struct packed {
		logic ok;
		logic [19:0] idx_base;
		logic [10:0] x;
		logic [4:0] dst_r;
		logic [5:0] dst_g;
		logic [4:0] dst_b;
		logic [4:0] src_r;
		logic [5:0] src_g;
		logic [4:0] src_b;
	} side_t;

	typedef struct packed {
		logic [15:0] op;
		logic [15:0] res;
	} sq_t;

	function automatic sq_t sqrt_step(sq_t s, logic [15:0] one);
		logic [15:0] trial;
		sq_t n;
		trial = s.res + one;
		if (s.op >= trial) begin
			n.op = s.op - trial;
			n.res = (s.res >> 1) + one;
		end else begin
			n.op = s.op;
			n.res = s.res >> 1;
		end
		return n;
	endfunction

	// floor(x/255), exact for x below 16320
	function automatic logic [5:0] div255(logic [13:0] x);
		logic [15:0] t;
		t = {2'b00, x} + {10'd0, x[13:8]} + 16'd1;
		return t[13:8];
	endfunction

endpackage

/* hdl/mab_front.sv */
module mab_front (
	input logic clk,
	input logic arst_n,
	input mab_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input logic [9:0] col,
	input logic [9:0] row,
	input logic [7:0] src_red,
	input logic [7:0] src_green,
	input logic [7:0] src_blue,
	input logic [7:0] mask_red,
	input logic [7:0] mask_green,
	input logic [7:0] mask_blue,
	input logic [15:0] dest_pixel,
	output logic out_valid,
	input logic out_stall,
	output mab_pkg::sq_t sq_out,
	output mab_pkg::side_t side_out
);

	logic v_s1, v_s2;
	logic stall_s1, stall_s2;

	logic signed [11:0] xt;
	logic signed [12:0] yt;
	logic in_bm;
	logic [9:0] msum;
	logic [19:0] mq;
	logic [7:0] m;

	logic signed [11:0] xt_s1;
	logic signed [12:0] yt_s1;
	logic in_bm_s1;
	logic [7:0] m_s1;
	logic [15:0] dst_s1;
	logic [4:0] sr_s1;
	logic [5:0] sg_s1;
	logic [4:0] sb_s1;

	logic in_fb;
	logic [21:0] yprod;

	mab_pkg::sq_t sq_s2;
	mab_pkg::side_t side_s2;

	assign stall_s2 = v_s2 && out_stall;
	assign stall_s1 = v_s1 && stall_s2;
	assign in_stall = stall_s1;

	assign xt = $signed({cfg.x_offset[10], cfg.x_offset}) + $signed({2'b00, col});
	assign yt = $signed({{2{cfg.y_offset[10]}}, cfg.y_offset})
		+ $signed({2'b00, cfg.image_height}) - $signed({3'b000, row});
	assign in_bm = ({1'b0, col} < cfg.image_width) && ({1'b0, row} < cfg.image_height)
		&& ({3'b000, col} < 13'(mab_pkg::MAX_DIM)) && ({3'b000, row} < 13'(mab_pkg::MAX_DIM));
	assign msum = {2'b00, mask_red} + {2'b00, mask_green} + {2'b00, mask_blue};
	assign mq = 20'({10'd0, msum} * 20'(mab_pkg::DIV3_MUL));
	assign m = 8'd255 - mq[mab_pkg::DIV3_SHIFT +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!stall_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1) begin
			xt_s1 <= xt;
			yt_s1 <= yt;
			in_bm_s1 <= in_bm;
			m_s1 <= m;
			dst_s1 <= dest_pixel;
			sr_s1 <= src_red[7:3];
			sg_s1 <= src_green[7:2];
			sb_s1 <= src_blue[7:3];
		end
	end

	// xt stays below 2047 and yt below 3071 once known non-negative
	assign in_fb = !xt_s1[11] && !yt_s1[12] && (xt_s1[10:0] < cfg.fb_width)
		&& (yt_s1[11:0] < {1'b0, cfg.fb_height});
	assign yprod = {11'd0, cfg.fb_width} * {11'd0, yt_s1[10:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!stall_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2) begin
			sq_s2.op <= {8'd0, m_s1} * {8'd0, cfg.global_alpha};
			sq_s2.res <= 16'd0;
			side_s2.ok <= in_bm_s1 && in_fb;
			side_s2.idx_base <= yprod[19:0];
			side_s2.x <= xt_s1[10:0];
			side_s2.dst_r <= dst_s1[15:11];
			side_s2.dst_g <= dst_s1[10:5];
			side_s2.dst_b <= dst_s1[4:0];
			side_s2.src_r <= sr_s1;
			side_s2.src_g <= sg_s1;
			side_s2.src_b <= sb_s1;
		end
	end

	assign out_valid = v_s2;
	assign sq_out = sq_s2;
	assign side_out = side_s2;

endmodule

/* hdl/mab_isqrt.sv */
module mab_isqrt (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mab_pkg::sq_t sq_in,
	input mab_pkg::side_t side_in,
	output logic out_valid,
	input logic out_stall,
	output mab_pkg::sq_t sq_out,
	output mab_pkg::side_t side_out
);

	localparam int N = mab_pkg::SQ_STAGES;
	localparam int K = mab_pkg::SQ_STEPS_PER_STAGE;

	logic vld_s [N];
	logic stall_s [N+1];
	logic valid_in_s [N];
	mab_pkg::sq_t sq_s [N];
	mab_pkg::side_t side_s [N];
	mab_pkg::sq_t sq_in_s [N];
	mab_pkg::side_t side_in_s [N];

	assign stall_s[N] = out_stall;
	assign in_stall = stall_s[0];

	for (genvar j = 0; j < N; j++) begin : g_stage
		mab_pkg::sq_t part [K+1];

		if (j == 0) begin : g_first
			assign valid_in_s[j] = in_valid;
			assign sq_in_s[j] = sq_in;
			assign side_in_s[j] = side_in;
		end else begin : g_next
			assign valid_in_s[j] = vld_s[j-1];
			assign sq_in_s[j] = sq_s[j-1];
			assign side_in_s[j] = side_s[j-1];
		end

		assign stall_s[j] = vld_s[j] && stall_s[j+1];

		assign part[0] = sq_in_s[j];
		for (genvar k = 0; k < K; k++) begin : g_step
			assign part[k+1] = mab_pkg::sqrt_step(part[k],
				16'(1) << (14 - 2 * (j * K + k)));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (!stall_s[j]) begin
				vld_s[j] <= valid_in_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (!stall_s[j]) begin
				sq_s[j] <= part[K];
				side_s[j] <= side_in_s[j];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign sq_out = sq_s[N-1];
	assign side_out = side_s[N-1];

endmodule

/* hdl/mab_blend.sv */
module mab_blend (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mab_pkg::sq_t sq_in,
	input mab_pkg::side_t side_in,
	output logic out_valid,
	input logic out_stall,
	output logic [19:0] fb_index,
	output logic write_enable,
	output logic [15:0] new_pixel
);

	logic v_s7, v_s8;
	logic stall_s7, stall_s8;
	logic [7:0] a;
	logic [7:0] na;

	logic ok_s7;
	logic [19:0] idx_s7;
	logic [13:0] r_s7, g_s7, b_s7;
	logic [5:0] r_div, g_div, b_div;

	logic [19:0] idx_s8;
	logic we_s8;
	logic [15:0] pix_s8;

	assign stall_s8 = v_s8 && out_stall;
	assign stall_s7 = v_s7 && stall_s8;
	assign in_stall = stall_s7;

	assign a = sq_in.res[7:0];
	assign na = 8'd255 - a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (!stall_s7) begin
				v_s7 <= in_valid;
			end
			if (!stall_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s7) begin
			ok_s7 <= side_in.ok;
			idx_s7 <= side_in.idx_base + {9'd0, side_in.x};
			r_s7 <= {9'd0, side_in.dst_r} * {6'd0, na} + {9'd0, side_in.src_r} * {6'd0, a};
			g_s7 <= {8'd0, side_in.dst_g} * {6'd0, na} + {8'd0, side_in.src_g} * {6'd0, a};
			b_s7 <= {9'd0, side_in.dst_b} * {6'd0, na} + {9'd0, side_in.src_b} * {6'd0, a};
		end
	end

	assign r_div = mab_pkg::div255(r_s7);
	assign g_div = mab_pkg::div255(g_s7);
	assign b_div = mab_pkg::div255(b_s7);

	// drop index and color of clipped pixels
	always_ff @(posedge clk) begin
		if (!stall_s8) begin
			we_s8 <= ok_s7;
			idx_s8 <= ok_s7 ? idx_s7 : 20'd0;
			pix_s8 <= ok_s7 ? {r_div[4:0], g_div, b_div[4:0]} : 16'd0;
		end
	end

	assign out_valid = v_s8;
	assign fb_index = idx_s8;
	assign write_enable = we_s8;
	assign new_pixel = pix_s8;

endmodule

/* hdl/masked_alpha_blend_rgb565.sv */
// Blends one 24-bit bitmap pixel per transfer into an RGB565 frame buffer word, weighted
// by the mask color (white is transparent) and global_alpha. A new pixel is taken every
// clock while in_stall is low, through eight register stages: two of placement, clipping
// and weight products, four of the integer square root (two result bits per stage), and
// two of channel mixing and repacking. Empty stages close up while the output stalls, so
// input is held off only when all eight stages are full. Clipped pixels come out with
// write_enable, fb_index and new_pixel all zero. Registers sit at byte addresses 4*i on
// the APB port; the first two stages read them, so write them only while no pixel is in
// flight.
module masked_alpha_blend_rgb565 (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [9:0] col,
	input logic [9:0] row,
	input logic [7:0] src_red,
	input logic [7:0] src_green,
	input logic [7:0] src_blue,
	input logic [7:0] mask_red,
	input logic [7:0] mask_green,
	input logic [7:0] mask_blue,
	input logic [15:0] dest_pixel,
	output logic out_valid,
	input logic out_stall,
	output logic [19:0] fb_index,
	output logic write_enable,
	output logic [15:0] new_pixel
);

	mab_pkg::cfg_t cfg_q;
	logic [2:0] reg_sel;
	logic wr;

	logic fv, fs, sv, ss;
	mab_pkg::sq_t f_sq, s_sq;
	mab_pkg::side_t f_side, s_side;

	assign pready = 1'b1;
	assign reg_sel = paddr[4:2];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset <= 11'sd0;
			cfg_q.y_offset <= 11'sd0;
			cfg_q.image_width <= 11'd1;
			cfg_q.image_height <= 11'd1;
			cfg_q.fb_width <= 11'd1;
			cfg_q.fb_height <= 11'd1;
			cfg_q.global_alpha <= 8'd255;
		end else if (wr) begin
			case (reg_sel)
				mab_pkg::REG_X_OFFSET: cfg_q.x_offset <= pwdata[10:0];
				mab_pkg::REG_Y_OFFSET: cfg_q.y_offset <= pwdata[10:0];
				mab_pkg::REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[10:0];
				mab_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[10:0];
				mab_pkg::REG_FB_WIDTH: cfg_q.fb_width <= pwdata[10:0];
				mab_pkg::REG_FB_HEIGHT: cfg_q.fb_height <= pwdata[10:0];
				mab_pkg::REG_GLOBAL_ALPHA: cfg_q.global_alpha <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mab_pkg::REG_X_OFFSET: prdata = {21'd0, cfg_q.x_offset};
			mab_pkg::REG_Y_OFFSET: prdata = {21'd0, cfg_q.y_offset};
			mab_pkg::REG_IMAGE_WIDTH: prdata = {21'd0, cfg_q.image_width};
			mab_pkg::REG_IMAGE_HEIGHT: prdata = {21'd0, cfg_q.image_height};
			mab_pkg::REG_FB_WIDTH: prdata = {21'd0, cfg_q.fb_width};
			mab_pkg::REG_FB_HEIGHT: prdata = {21'd0, cfg_q.fb_height};
			mab_pkg::REG_GLOBAL_ALPHA: prdata = {24'd0, cfg_q.global_alpha};
			default: prdata = 32'd0;
		endcase
	end

	mab_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.col(col),
		.row(row),
		.src_red(src_red),
		.src_green(src_green),
		.src_blue(src_blue),
		.mask_red(mask_red),
		.mask_green(mask_green),
		.mask_blue(mask_blue),
		.dest_pixel(dest_pixel),
		.out_valid(fv),
		.out_stall(fs),
		.sq_out(f_sq),
		.side_out(f_side)
	);

	mab_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fv),
		.in_stall(fs),
		.sq_in(f_sq),
		.side_in(f_side),
		.out_valid(sv),
		.out_stall(ss),
		.sq_out(s_sq),
		.side_out(s_side)
	);

	mab_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sv),
		.in_stall(ss),
		.sq_in(s_sq),
		.side_in(s_side),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fb_index(fb_index),
		.write_enable(write_enable),
		.new_pixel(new_pixel)
	);

endmodule
